FILE: sv/rebin_pkg.sv
// Shared types, constants and helper functions for the residual event binarizer.
`timescale 1ns / 1ps
`default_nettype none

package rebin_pkg;

    // Key table geometry.
    localparam int POSITION_KEYS          = 32;
    localparam int REMAINDER_LENGTH_LIMIT = 16;

    // Field widths.
    localparam int SAMPLE_W = 32;
    localparam int MAG_W    = 31;
    localparam int KEY_W    = 10;
    localparam int KIND_W   = 3;
    localparam int THR_W    = 6;
    localparam int IDX_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int TDATA_W  = ((KEY_W + MAG_W + 7) / 8) * 8;
    localparam int PAD_W    = TDATA_W - KEY_W - MAG_W;

    // Threshold limits and register reset values.
    localparam logic [THR_W-1:0] THR_MIN   = THR_W'(1);
    localparam logic [THR_W-1:0] THR_MAX   = THR_W'(32);
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(4);

    // Shared key for remainder bits of long remainders.
    localparam logic [KEY_W-1:0] REM_OVERFLOW_KEY =
        KEY_W'(REMAINDER_LENGTH_LIMIT * (REMAINDER_LENGTH_LIMIT + 1) / 2);

    typedef enum logic [KIND_W-1:0] {
        KIND_ZERO  = 3'd0,
        KIND_SIGN  = 3'd1,
        KIND_POS   = 3'd2,
        KIND_REM   = 3'd3,
        KIND_TOKEN = 3'd4,
        KIND_ESCQ  = 3'd5,
        KIND_RAW   = 3'd6
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROFILE     = 2'd0,
        REG_THRESHOLD   = 2'd1,
        REG_PROGRESSIVE = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ZERO,
        ST_TOKEN,
        ST_SIGN,
        ST_POS,
        ST_REM,
        ST_ESCQ,
        ST_RAW
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic  accept;
        logic  emit;
        kind_t kind;
        logic  last;
    } rebin_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic profile;
        logic mag_zero;
        logic escape;
        logic unary_end;
        logic k_zero;
        logic rem_end;
        logic out_free;
    } rebin_status_t;

    // Position key, capped at the last position context.
    function automatic logic [IDX_W-1:0] cap_key(input logic [IDX_W-1:0] k);
        cap_key = (int'(k) < POSITION_KEYS - 1) ? k : IDX_W'(POSITION_KEYS - 1);
    endfunction

    // First key of the remainder row for a remainder of len bits.
    function automatic logic [KEY_W-1:0] tri_base(input logic [IDX_W-1:0] len);
        int prod;
        prod = int'(len) * (int'(len) - 1);
        tri_base = KEY_W'(prod / 2);
    endfunction

    // Escape quotient key from its context row and position.
    function automatic logic [KEY_W-1:0] esc_key(input logic [IDX_W-1:0] ctx,
                                                 input logic [IDX_W-1:0] k);
        int sum;
        sum = int'(ctx) * POSITION_KEYS + int'(cap_key(k));
        esc_key = KEY_W'(sum);
    endfunction

endpackage

`default_nettype wire

FILE: sv/rebin_ctrl.sv
// Sequencing state machine: walks the event phases of one sample.
`timescale 1ns / 1ps
`default_nettype none

module rebin_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire rebin_pkg::rebin_status_t sts,
    output rebin_pkg::rebin_cmd_t       cmd
);
    import rebin_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands. In each event phase an event is emitted whenever the output stage is free.
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.emit   = 1'b0;
        cmd.kind   = KIND_ZERO;
        cmd.last   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = sts.profile ? ST_TOKEN : ST_ZERO;
                end
            end
            ST_ZERO: begin
                cmd.kind = KIND_ZERO;
                cmd.last = sts.mag_zero;
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    state_next = sts.mag_zero ? ST_IDLE : ST_SIGN;
                end
            end
            ST_TOKEN: begin
                cmd.kind = KIND_TOKEN;
                cmd.last = sts.mag_zero;
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    state_next = sts.mag_zero ? ST_IDLE : ST_SIGN;
                end
            end
            ST_SIGN: begin
                cmd.kind = KIND_SIGN;
                cmd.last = sts.profile && !sts.escape;
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    if (!sts.profile) begin
                        state_next = ST_POS;
                    end else begin
                        state_next = sts.escape ? ST_ESCQ : ST_IDLE;
                    end
                end
            end
            ST_POS: begin
                cmd.kind = KIND_POS;
                cmd.last = sts.unary_end && sts.k_zero;
                cmd.emit = sts.out_free;
                if (sts.out_free && sts.unary_end) begin
                    state_next = sts.k_zero ? ST_IDLE : ST_REM;
                end
            end
            ST_REM: begin
                cmd.kind = KIND_REM;
                cmd.last = sts.rem_end;
                cmd.emit = sts.out_free;
                if (sts.out_free && sts.rem_end) begin
                    state_next = ST_IDLE;
                end
            end
            ST_ESCQ: begin
                cmd.kind = KIND_ESCQ;
                cmd.emit = sts.out_free;
                if (sts.out_free && sts.unary_end) begin
                    state_next = ST_RAW;
                end
            end
            ST_RAW: begin
                cmd.kind = KIND_RAW;
                cmd.last = 1'b1;
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/rebin_dp.sv
// Datapath: configuration registers, magnitude and unary shifters, event output stage.
`timescale 1ns / 1ps
`default_nettype none

module rebin_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [rebin_pkg::SAMPLE_W-1:0]    s_tdata,
    input  wire logic                              cfg_valid,
    input  wire logic [rebin_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rebin_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire rebin_pkg::rebin_cmd_t             cmd,
    output rebin_pkg::rebin_status_t               sts,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [rebin_pkg::TDATA_W-1:0]          m_tdata,
    output logic [rebin_pkg::KIND_W-1:0]           m_tuser,
    output logic                                   m_tlast
);
    import rebin_pkg::*;

    // Configuration registers.
    logic             profile_reg;
    logic [THR_W-1:0] thr_reg;
    logic             prog_reg;

    // Per-sample working registers.
    logic [MAG_W-1:0] mag_reg;
    logic             neg_reg;
    logic             esc_reg;
    logic [MAG_W-1:0] sh_reg;
    logic [MAG_W-1:0] top_reg;
    logic [MAG_W-1:0] ptr_reg;
    logic [IDX_W-1:0] k_reg;
    logic [KEY_W-1:0] rkey_reg;
    logic             rinc_reg;

    // Output stage.
    logic             ovalid_reg;
    kind_t            okind_reg;
    logic [KEY_W-1:0] okey_reg;
    logic [MAG_W-1:0] oval_reg;
    logic             olast_reg;

    logic [THR_W-1:0]    thr_eff;
    logic [MAG_W-1:0]    thr_mag;
    logic [IDX_W-1:0]    thr_m1;
    logic [IDX_W-1:0]    ctx;
    logic [SAMPLE_W-1:0] neg_sample;
    logic [SAMPLE_W-1:0] abs_sample;
    logic [MAG_W-1:0]    in_mag;
    logic                mag_zero;
    logic                mag_ge;
    logic                unary_end;
    logic [KEY_W-1:0]    ev_key;
    logic [MAG_W-1:0]    ev_val;

    // Configuration writes; the port never stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            profile_reg <= 1'b0;
            thr_reg     <= THR_RESET;
            prog_reg    <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PROFILE:     profile_reg <= cfg_data[0];
                REG_THRESHOLD:   thr_reg     <= cfg_data;
                REG_PROGRESSIVE: prog_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Threshold clamped to its legal range.
    always_comb begin
        if (thr_reg < THR_MIN) begin
            thr_eff = THR_MIN;
        end else if (thr_reg > THR_MAX) begin
            thr_eff = THR_MAX;
        end else begin
            thr_eff = thr_reg;
        end
    end

    assign thr_mag = MAG_W'(thr_eff);
    assign thr_m1  = IDX_W'(thr_eff - THR_MIN);

    // Magnitude of the incoming sample; the most negative value saturates.
    assign neg_sample = SAMPLE_W'(0) - s_tdata;
    assign abs_sample = s_tdata[SAMPLE_W-1] ? neg_sample : s_tdata;
    assign in_mag     = abs_sample[SAMPLE_W-1] ? {MAG_W{1'b1}} : abs_sample[MAG_W-1:0];

    assign mag_zero  = (mag_reg == '0);
    assign mag_ge    = (mag_reg >= thr_mag);
    assign unary_end = (sh_reg[MAG_W-1:1] == '0);
    assign ctx       = prog_reg ? ((k_reg < thr_m1) ? k_reg : thr_m1) : '0;

    // Key and value of the event for the current phase.
    always_comb begin
        ev_key = '0;
        ev_val = '0;
        case (cmd.kind)
            KIND_ZERO:  ev_val = MAG_W'(mag_zero);
            KIND_TOKEN: ev_val = mag_zero ? '0 : (mag_ge ? thr_mag : mag_reg);
            KIND_SIGN:  ev_val = MAG_W'(neg_reg);
            KIND_POS: begin
                ev_key = KEY_W'(cap_key(k_reg));
                ev_val = MAG_W'(unary_end);
            end
            KIND_REM: begin
                ev_key = rkey_reg;
                ev_val = MAG_W'(|(mag_reg & ptr_reg));
            end
            KIND_ESCQ: begin
                ev_key = esc_key(ctx, k_reg);
                ev_val = MAG_W'(unary_end);
            end
            KIND_RAW: begin
                ev_key = KEY_W'(k_reg);
                ev_val = mag_reg & ~top_reg;
            end
            default: ;
        endcase
    end

    // Working registers: loaded on accept, advanced as each event is emitted.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mag_reg <= in_mag;
            sh_reg  <= in_mag;
            neg_reg <= s_tdata[SAMPLE_W-1];
            top_reg <= MAG_W'(1);
            k_reg   <= '0;
        end else if (cmd.emit) begin
            case (cmd.kind)
                KIND_TOKEN: begin
                    // Escape value: magnitude minus threshold plus one.
                    mag_reg <= mag_reg - thr_mag + MAG_W'(1);
                    sh_reg  <= mag_reg - thr_mag + MAG_W'(1);
                    esc_reg <= mag_ge;
                end
                KIND_POS, KIND_ESCQ: begin
                    if (!unary_end) begin
                        sh_reg  <= sh_reg >> 1;
                        top_reg <= top_reg << 1;
                        k_reg   <= k_reg + IDX_W'(1);
                    end else begin
                        ptr_reg  <= top_reg >> 1;
                        rinc_reg <= (int'(k_reg) <= REMAINDER_LENGTH_LIMIT);
                        rkey_reg <= (int'(k_reg) <= REMAINDER_LENGTH_LIMIT)
                                    ? tri_base(k_reg) : REM_OVERFLOW_KEY;
                    end
                end
                KIND_REM: begin
                    ptr_reg <= ptr_reg >> 1;
                    if (rinc_reg) begin
                        rkey_reg <= rkey_reg + KEY_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Output stage: holds one event until the downstream side takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            ovalid_reg <= 1'b1;
        end else if (m_tready) begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            okind_reg <= cmd.kind;
            okey_reg  <= ev_key;
            oval_reg  <= ev_val;
            olast_reg <= cmd.last;
        end
    end

    assign sts.profile   = profile_reg;
    assign sts.mag_zero  = mag_zero;
    assign sts.escape    = esc_reg;
    assign sts.unary_end = unary_end;
    assign sts.k_zero    = (k_reg == '0);
    assign sts.rem_end   = ptr_reg[0];
    assign sts.out_free  = !ovalid_reg || m_tready;

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, oval_reg, okey_reg};
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;

endmodule

`default_nettype wire

FILE: sv/residual_event_binarizer_unit.sv
// Top level of the residual event binarizer: controller and datapath.
//
//  Channel  | Direction | Payload
//  ---------+-----------+----------------------------------------------------
//  s_       | in        | tdata[31:0] = sample
//  m_       | out       | tdata = context_key, event_value; tuser = event_kind;
//           |           | tlast = last_event
//  cfg_     | in        | index = register number, data = register value
//
// One sample is accepted, then its events leave one per cycle while the output
// is not stalled; the event count is set by the bit length of the magnitude and
// the profile.
// The next sample is accepted while the last event of the previous one waits.
// A stalled output holds the event stage and freezes the sequencer.
// Reset (aresetn low, synchronous) idles the sequencer, empties the output
// stage and restores mode 0, threshold 4 and progressive contexts on.
`timescale 1ns / 1ps
`default_nettype none

module residual_event_binarizer_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input stream.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [rebin_pkg::SAMPLE_W-1:0]    s_tdata,  // [31:0] sample
    // Event stream.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [rebin_pkg::TDATA_W-1:0]          m_tdata,  // [9:0] context_key,
                                                             // [40:10] event_value, zeros
    output logic [rebin_pkg::KIND_W-1:0]           m_tuser,  // [2:0] event_kind
    output logic                                   m_tlast,
    // Register writes.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [rebin_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rebin_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rebin_pkg::*;

    rebin_cmd_t    cmd;
    rebin_status_t sts;

    assign cfg_ready = 1'b1;

    rebin_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rebin_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

FILE: sv/rebin_checker.sv
// Port-level checks for the residual event binarizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rebin_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [rebin_pkg::TDATA_W-1:0]     m_tdata,
    input wire logic [rebin_pkg::KIND_W-1:0]      m_tuser,
    input wire logic                              m_tlast
);
    import rebin_pkg::*;

    // Set when the next event on the output opens a new sample.
    logic first_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
        end else if (m_tvalid && m_tready) begin
            first_reg <= m_tlast;
        end
    end

    // The output stage is empty after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("event output valid after reset");

    // A stalled event stays put.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled event changed");

    // One sample at a time: no second accept right after an accept.
    a_one_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted sample");

    // Every sample opens with a zero flag or a token.
    a_first_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && first_reg |->
            m_tuser == KIND_ZERO || m_tuser == KIND_TOKEN)
        else $error("sample does not open with zero flag or token");

    // Zero flags and tokens never appear inside a sample.
    a_inner_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !first_reg |->
            m_tuser != KIND_ZERO && m_tuser != KIND_TOKEN)
        else $error("zero flag or token inside a sample");

endmodule

bind residual_event_binarizer_unit rebin_checker u_rebin_checker (.*);

`default_nettype wire
